// ----- rtl/nmlm_pkg.sv -----
// ----------------------------------------------------------------------------
// Named mutex lock manager package
// Shared constants, status codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package nmlm_pkg;

    localparam int TABLE_ENTRIES_DEF  = 16;
    localparam int SLOTS_PER_PROC_DEF = 4;
    localparam int PROCS_DEF          = 8;
    localparam int NAME_BYTES_DEF     = 8;

    // Request modes.
    localparam logic [1:0] MODE_OPEN   = 2'd0;
    localparam logic [1:0] MODE_CLOSE  = 2'd1;
    localparam logic [1:0] MODE_LOCK   = 2'd2;
    localparam logic [1:0] MODE_UNLOCK = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_DESC  = 3'd1;
    localparam logic [2:0] ST_NO_SLOT   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_OWNER     = 3'd4;
    localparam logic [2:0] ST_NOT_OWNER = 3'd5;
    localparam logic [2:0] ST_DEADLOCK  = 3'd6;
    localparam logic [2:0] ST_BLOCKED   = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the request word
        logic decode;      // resolve slot and entry, write status
        logic scan_start;  // clear the search index
        logic scan_step;   // test one table entry / waiter / chain link
        logic commit;      // apply the state update
        logic out_load;    // load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;   // current scan has finished
        logic need_scan;   // the request needs a scan phase
    } stat_t;

endpackage

// ----- rtl/nmlm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Named mutex lock manager controller
// Sequences capture, decode, scan and commit of one request word.
// ----------------------------------------------------------------------------
module nmlm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic            out_busy,
    input  nmlm_pkg::stat_t stat,
    output logic            idle,
    output nmlm_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode     = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN: begin
                if (stat.scan_done || !stat.need_scan) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

endmodule

// ----- rtl/nmlm_datapath.sv -----
// ----------------------------------------------------------------------------
// Named mutex lock manager datapath
// Holds the mutex table, descriptor slots and waiter set, and walks them.
// ----------------------------------------------------------------------------
module nmlm_datapath #(
    parameter int TABLE_ENTRIES  = nmlm_pkg::TABLE_ENTRIES_DEF,
    parameter int SLOTS_PER_PROC = nmlm_pkg::SLOTS_PER_PROC_DEF,
    parameter int PROCS          = nmlm_pkg::PROCS_DEF,
    parameter int NAME_BYTES     = nmlm_pkg::NAME_BYTES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  nmlm_pkg::cmd_t  cmd,
    output nmlm_pkg::stat_t stat,
    input  logic [1:0]      s_mode,
    input  logic [2:0]      s_proc_id,
    input  logic [7:0]      s_proc_priority,
    input  logic [63:0]     s_name_key,
    input  logic [2:0]      s_local_desc,
    output logic [2:0]      res_status,
    output logic [2:0]      res_desc,
    output logic            res_woken_valid,
    output logic [2:0]      res_woken_proc
);

    localparam int EW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LW     = (SLOTS_PER_PROC > 1) ? $clog2(SLOTS_PER_PROC) : 1;
    localparam int NSLOTS = PROCS * SLOTS_PER_PROC;
    localparam int SW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int PW     = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int NBITS  = 8 * NAME_BYTES;
    // Scan index runs over table entries and processes.
    localparam int SCAN_MAX = (TABLE_ENTRIES > PROCS) ? TABLE_ENTRIES : PROCS;
    localparam int IW       = $clog2(SCAN_MAX + 1);

    // Table, slot and waiter state.
    logic [TABLE_ENTRIES-1:0] used_reg, locked_reg;
    logic [NBITS-1:0]         name_reg   [TABLE_ENTRIES];
    logic [5:0]               refs_reg   [TABLE_ENTRIES];
    logic [2:0]               owner_reg  [TABLE_ENTRIES];
    logic [NSLOTS-1:0]        sopen_reg;
    logic [EW-1:0]            sentry_reg [NSLOTS];
    logic [PROCS-1:0]         wvalid_reg, blocked_reg;
    logic [EW-1:0]            wentry_reg [PROCS];
    logic [7:0]               wprio_reg  [PROCS];
    logic [15:0]              wstamp_reg [PROCS];
    logic [15:0]              stamp_reg;

    // Captured request word.
    logic [1:0]       mode_reg;
    logic [2:0]       proc_reg;
    logic [7:0]       prio_reg;
    logic [NBITS-1:0] key_reg;
    logic [2:0]       desc_reg;

    // Decode results.
    logic [2:0]    status_reg;
    logic          pvalid_reg;
    logic [LW-1:0] loc_reg;
    logic [SW-1:0] slot_reg;
    logic [EW-1:0] e_reg;
    logic          need_reg;

    // Scan state.
    logic [IW-1:0] idx_reg;
    logic          found_reg, free_found_reg;
    logic [EW-1:0] found_e_reg, free_e_reg;
    logic [2:0]    aux_reg;
    logic          chain_done_reg, cycle_reg;
    logic          best_found_reg;
    logic [PW-1:0] best_reg;
    logic [7:0]    best_prio_reg;
    logic [15:0]   best_age_reg;

    // Result words.
    logic [2:0] o_status_reg, o_desc_reg, o_wproc_reg;
    logic       o_wvalid_reg;

    // Free local slot of the captured process, first one wins.
    logic          loc_ok;
    logic [LW-1:0] loc_sel;
    logic [SW-1:0] pbase;
    always_comb begin
        pbase   = SW'(proc_reg[PW-1:0]) * SW'(SLOTS_PER_PROC);
        loc_ok  = 1'b0;
        loc_sel = '0;
        for (int i = SLOTS_PER_PROC - 1; i >= 0; i--) begin
            if (!sopen_reg[pbase + SW'(i)]) begin
                loc_ok  = 1'b1;
                loc_sel = LW'(i);
            end
        end
    end

    logic [SW-1:0] dslot;
    logic          desc_ok;
    assign dslot   = pbase + SW'(desc_reg);
    assign desc_ok = (32'(desc_reg) < SLOTS_PER_PROC);

    // Entry behind the addressed descriptor and whether the caller holds it.
    logic          mine_d;
    logic [EW-1:0] de;
    assign de     = sentry_reg[dslot];
    assign mine_d = locked_reg[de] && (owner_reg[de] == proc_reg);

    // Per-step scan views.
    logic [EW-1:0] idx_e;
    logic [PW-1:0] idx_p;
    logic [15:0]   idx_age;
    logic [PW-1:0] aux_p;
    assign idx_e   = idx_reg[EW-1:0];
    assign idx_p   = idx_reg[PW-1:0];
    assign idx_age = stamp_reg - wstamp_reg[idx_p];
    assign aux_p   = aux_reg[PW-1:0];

    // Which scan applies: open searches table, lock walks chain, release
    // picks a waiter.
    logic is_open, is_lock_chain, is_release;
    assign is_open       = (mode_reg == nmlm_pkg::MODE_OPEN);
    assign is_lock_chain = (mode_reg == nmlm_pkg::MODE_LOCK);
    assign is_release    = (mode_reg == nmlm_pkg::MODE_CLOSE) ||
                           (mode_reg == nmlm_pkg::MODE_UNLOCK);

    always_comb begin
        stat.need_scan = need_reg;
        if (is_open) begin
            stat.scan_done = (32'(idx_reg) >= TABLE_ENTRIES);
        end else if (is_lock_chain) begin
            stat.scan_done = chain_done_reg || (32'(idx_reg) >= PROCS);
        end else begin
            stat.scan_done = (32'(idx_reg) >= PROCS);
        end
    end

    // Status decode before any scan.
    logic [2:0] dec_status;
    logic       dec_need;
    always_comb begin
        dec_status = nmlm_pkg::ST_OK;
        dec_need   = 1'b0;
        if (32'(proc_reg) >= PROCS) begin
            dec_status = nmlm_pkg::ST_BAD_DESC;
        end else if (is_open) begin
            if (!loc_ok) begin
                dec_status = nmlm_pkg::ST_NO_SLOT;
            end else begin
                dec_need = 1'b1;
            end
        end else if (!desc_ok || !sopen_reg[dslot]) begin
            dec_status = nmlm_pkg::ST_BAD_DESC;
        end else begin
            case (mode_reg)
                nmlm_pkg::MODE_CLOSE: dec_need = mine_d;
                nmlm_pkg::MODE_UNLOCK: begin
                    if (!mine_d) begin
                        dec_status = nmlm_pkg::ST_NOT_OWNER;
                    end else begin
                        dec_need = 1'b1;
                    end
                end
                default: begin
                    if (mine_d) begin
                        dec_status = nmlm_pkg::ST_OWNER;
                    end else if (locked_reg[sentry_reg[dslot]]) begin
                        dec_need = 1'b1;
                    end
                end
            endcase
        end
    end

    // Final values of the entry chosen by open.
    logic          open_new;
    logic [EW-1:0] open_e;
    assign open_new = !found_reg;
    assign open_e   = found_reg ? found_e_reg : free_e_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            locked_reg  <= '0;
            sopen_reg   <= '0;
            wvalid_reg  <= '0;
            blocked_reg <= '0;
            stamp_reg   <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                refs_reg[i] <= '0;
            end
        end else begin
            if (cmd.capture) begin
                mode_reg <= s_mode;
                proc_reg <= s_proc_id;
                prio_reg <= s_proc_priority;
                key_reg  <= s_name_key[NBITS-1:0];
                desc_reg <= s_local_desc;
            end
            if (cmd.decode) begin
                status_reg <= dec_status;
                need_reg   <= dec_need;
                pvalid_reg <= (32'(proc_reg) < PROCS);
                loc_reg    <= loc_sel;
                slot_reg   <= is_open ? (pbase + SW'(loc_sel)) : dslot;
                e_reg      <= de;
                aux_reg    <= owner_reg[de];
                // A request shows the process is running: leave the waiters.
                if (32'(proc_reg) < PROCS) begin
                    wvalid_reg[proc_reg[PW-1:0]]  <= 1'b0;
                    blocked_reg[proc_reg[PW-1:0]] <= 1'b0;
                end
            end
            if (cmd.scan_start) begin
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                chain_done_reg <= 1'b0;
                cycle_reg      <= 1'b0;
                best_found_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (is_open) begin
                    // Name search and first free entry in one pass.
                    if (used_reg[idx_e] && name_reg[idx_e] == key_reg &&
                        !found_reg) begin
                        found_reg   <= 1'b1;
                        found_e_reg <= idx_e;
                    end
                    if (!used_reg[idx_e] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_e_reg     <= idx_e;
                    end
                end else if (is_lock_chain) begin
                    // One link of the owner chain.
                    if (aux_reg == proc_reg) begin
                        cycle_reg      <= 1'b1;
                        chain_done_reg <= 1'b1;
                    end else if (32'(aux_reg) >= PROCS || !wvalid_reg[aux_p] ||
                                 !locked_reg[wentry_reg[aux_p]]) begin
                        chain_done_reg <= 1'b1;
                    end else begin
                        aux_reg <= owner_reg[wentry_reg[aux_p]];
                    end
                end else if (is_release) begin
                    // Best waiter: highest priority, then oldest.
                    if (blocked_reg[idx_p] && wentry_reg[idx_p] == e_reg &&
                        (!best_found_reg || wprio_reg[idx_p] > best_prio_reg ||
                         (wprio_reg[idx_p] == best_prio_reg &&
                          idx_age > best_age_reg))) begin
                        best_found_reg <= 1'b1;
                        best_reg       <= idx_p;
                        best_prio_reg  <= wprio_reg[idx_p];
                        best_age_reg   <= idx_age;
                    end
                end
            end
            if (cmd.commit) begin
                o_status_reg <= status_reg;
                o_desc_reg   <= '0;
                o_wvalid_reg <= 1'b0;
                o_wproc_reg  <= '0;
                if (status_reg == nmlm_pkg::ST_OK && pvalid_reg) begin
                    unique case (mode_reg)
                        nmlm_pkg::MODE_OPEN: begin
                            if (open_new && !free_found_reg) begin
                                o_status_reg <= nmlm_pkg::ST_FULL;
                            end else begin
                                o_desc_reg          <= 3'(loc_reg);
                                sopen_reg[slot_reg]  <= 1'b1;
                                sentry_reg[slot_reg] <= open_e;
                                if (open_new) begin
                                    used_reg[open_e]   <= 1'b1;
                                    name_reg[open_e]   <= key_reg;
                                    refs_reg[open_e]   <= 6'd1;
                                    locked_reg[open_e] <= 1'b0;
                                    owner_reg[open_e]  <= '0;
                                    for (int i = 0; i < PROCS; i++) begin
                                        if (blocked_reg[i] &&
                                            wentry_reg[i] == open_e) begin
                                            wvalid_reg[i]  <= 1'b0;
                                            blocked_reg[i] <= 1'b0;
                                        end
                                    end
                                end else if (refs_reg[open_e] != 6'd63) begin
                                    refs_reg[open_e] <= refs_reg[open_e] + 6'd1;
                                end
                            end
                        end
                        nmlm_pkg::MODE_LOCK: begin
                            if (!locked_reg[e_reg]) begin
                                locked_reg[e_reg] <= 1'b1;
                                owner_reg[e_reg]  <= proc_reg;
                            end else if (cycle_reg) begin
                                o_status_reg <= nmlm_pkg::ST_DEADLOCK;
                            end else begin
                                wvalid_reg[proc_reg[PW-1:0]]  <= 1'b1;
                                blocked_reg[proc_reg[PW-1:0]] <= 1'b1;
                                wentry_reg[proc_reg[PW-1:0]]  <= e_reg;
                                wprio_reg[proc_reg[PW-1:0]]   <= prio_reg;
                                wstamp_reg[proc_reg[PW-1:0]]  <= stamp_reg;
                                stamp_reg    <= stamp_reg + 16'd1;
                                o_status_reg <= nmlm_pkg::ST_BLOCKED;
                            end
                        end
                        default: begin
                            // Close and unlock.
                            if (need_reg) begin
                                locked_reg[e_reg] <= 1'b0;
                                if (best_found_reg) begin
                                    wvalid_reg[best_reg]  <= 1'b0;
                                    blocked_reg[best_reg] <= 1'b0;
                                    o_wvalid_reg          <= 1'b1;
                                    o_wproc_reg           <= 3'(best_reg);
                                end
                            end
                            if (mode_reg == nmlm_pkg::MODE_CLOSE) begin
                                sopen_reg[slot_reg] <= 1'b0;
                                if (refs_reg[e_reg] != 6'd0) begin
                                    refs_reg[e_reg] <= refs_reg[e_reg] - 6'd1;
                                end
                                if (refs_reg[e_reg] <= 6'd1) begin
                                    used_reg[e_reg] <= 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end
        end
    end

    assign res_status      = o_status_reg;
    assign res_desc        = o_desc_reg;
    assign res_woken_valid = o_wvalid_reg;
    assign res_woken_proc  = o_wproc_reg;

endmodule

// ----- rtl/named_mutex_lock_manager_core.sv -----
// Sequence: capture, decode, a scan of the table entries (open), the processes
// (release) or the owner-chain links (lock) where one is needed, commit, output.
// Throughput: one request word at a time; the next word is taken while the
// previous result still waits in the output register.
// Reset: synchronous, active low; clears table, slots, waiters and stamp.
// ----------------------------------------------------------------------------
// Named mutex lock manager core
// Top level: handshake, result register, controller and datapath.
// ----------------------------------------------------------------------------
module named_mutex_lock_manager_core #(
    parameter int TABLE_ENTRIES  = nmlm_pkg::TABLE_ENTRIES_DEF,
    parameter int SLOTS_PER_PROC = nmlm_pkg::SLOTS_PER_PROC_DEF,
    parameter int PROCS          = nmlm_pkg::PROCS_DEF,
    parameter int NAME_BYTES     = nmlm_pkg::NAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [2:0]  s_proc_id,
    input  logic [7:0]  s_proc_priority,
    input  logic [63:0] s_name_key,
    input  logic [2:0]  s_local_desc,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [2:0]  m_desc_out,
    output logic        m_woken_valid,
    output logic [2:0]  m_woken_proc
);

    nmlm_pkg::cmd_t  cmd;
    nmlm_pkg::stat_t stat;
    logic            idle;
    logic            m_valid_reg;
    logic [2:0]      res_status, res_desc, res_wproc;
    logic            res_wvalid;
    logic [2:0]      status_reg, desc_reg, wproc_reg;
    logic            wvalid_reg;

    assign s_ready = idle;

    nmlm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (s_valid && s_ready),
        .out_busy (m_valid_reg && !m_ready),
        .stat     (stat),
        .idle     (idle),
        .cmd      (cmd)
    );

    nmlm_datapath #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .SLOTS_PER_PROC (SLOTS_PER_PROC),
        .PROCS          (PROCS),
        .NAME_BYTES     (NAME_BYTES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_mode          (s_mode),
        .s_proc_id       (s_proc_id),
        .s_proc_priority (s_proc_priority),
        .s_name_key      (s_name_key),
        .s_local_desc    (s_local_desc),
        .res_status      (res_status),
        .res_desc        (res_desc),
        .res_woken_valid (res_wvalid),
        .res_woken_proc  (res_wproc)
    );

    // Output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
                status_reg  <= res_status;
                desc_reg    <= res_desc;
                wvalid_reg  <= res_wvalid;
                wproc_reg   <= res_wproc;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_desc_out    = desc_reg;
    assign m_woken_valid = wvalid_reg;
    assign m_woken_proc  = wproc_reg;

endmodule
